### hdl/kar_pkg.sv
// kar_pkg: shared constants, register indexes and types of the key auto-repeat block
// no dependencies
`timescale 1ns / 1ps

package kar_pkg;

    localparam int NUM_KEYS    = 16;
    localparam int MASK_W      = 16;
    localparam int ACTIVE_KEYS = (NUM_KEYS < MASK_W) ? NUM_KEYS : MASK_W;
    localparam int KEY_IDX_W   = (ACTIVE_KEYS > 1) ? $clog2(ACTIVE_KEYS) : 1;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] DEFAULT_PERIOD = CFG_W'(200);
    localparam logic [CFG_W-1:0] DEFAULT_HOLD   = CFG_W'(1000);
    localparam int               SPEEDUP_DIV    = 3;
    localparam logic [CFG_W-1:0] DEFAULT_FAST   = CFG_W'(200 / SPEEDUP_DIV);

    // floor(x / 3) as (x * 43691) >> 17, exact for all 16-bit x
    localparam int               DIV3_MULT_W = 17;
    localparam logic [DIV3_MULT_W-1:0] DIV3_MULT = DIV3_MULT_W'(43691);
    localparam int               DIV3_SHIFT  = 17;

    typedef struct packed {
        logic              down;
        logic [TIME_W-1:0] press;
        logic [TIME_W-1:0] fire;
    } key_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] period;
        logic [CFG_W-1:0] fast_period;
        logic [CFG_W-1:0] hold;
    } repeat_cfg_t;

endpackage

### hdl/kar_state_mem.sv
// kar_state_mem: per-key state memory, registered read, write forwarding
// depends on kar_pkg
`timescale 1ns / 1ps

module kar_state_mem
    import kar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [KEY_IDX_W-1:0] rd_addr,
    output key_state_t           rd_data,
    input  logic                 wr_en,
    input  logic [KEY_IDX_W-1:0] wr_addr,
    input  key_state_t           wr_data
);

    key_state_t             mem [ACTIVE_KEYS];
    logic [ACTIVE_KEYS-1:0] valid_reg;
    key_state_t             rdata_reg;
    logic                   rd_valid_reg;
    logic                   fwd_hit_reg;
    key_state_t             fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // never-written entries read as the reset state
    assign rd_data = fwd_hit_reg  ? fwd_data_reg :
                     rd_valid_reg ? rdata_reg    : '0;

endmodule

### hdl/kar_key_unit.sv
// kar_key_unit: edge detection and repeat timing for one key
// depends on kar_pkg
`timescale 1ns / 1ps

module kar_key_unit
    import kar_pkg::*;
(
    input  repeat_cfg_t       cfg,
    input  logic [TIME_W-1:0] now,
    input  logic              level,
    input  key_state_t        cur,
    output key_state_t        nxt,
    output logic              fired
);

    logic [TIME_W-1:0] held_for;
    logic [TIME_W-1:0] since_fire;
    logic [CFG_W-1:0]  rate;

    always_comb
    begin
        held_for   = now - cur.press;
        since_fire = now - cur.fire;
        rate       = ((cfg.hold != '0) && (held_for > TIME_W'(cfg.hold)))
                     ? cfg.fast_period : cfg.period;
        nxt        = cur;
        fired      = 1'b0;
        if (level != cur.down)
        begin
            if (level)
            begin
                nxt.down  = 1'b1;
                nxt.press = now;
                nxt.fire  = now;
                fired     = 1'b1;
            end
            else
            begin
                nxt = '0;
            end
        end
        else if (cur.down && (cfg.period != '0) && (since_fire > TIME_W'(rate)))
        begin
            nxt.fire = now;
            fired    = 1'b1;
        end
    end

endmodule

### hdl/key_auto_repeat.sv
// key_auto_repeat: top level, key sequencer, state read-modify-write and output word
// depends on kar_pkg, kar_state_mem, kar_key_unit
`timescale 1ns / 1ps

// Typematic auto-repeat for a bank of keys. Each input word is one tick (time stamp
// and raw key levels); each yields one output word, the mask of keys firing on that
// tick. Keys are served one per cycle, unless the key pipeline is held, from a state
// memory of one entry per key, and a new tick is taken at the edge that reads the
// last key of the previous one. The output register lets the next tick proceed while
// a result waits; only a second finished result stalls the key pipeline. State
// resets to all zero at once, with no clearing pass. Writes to repeat_period and
// hold_threshold must come while the block is idle; the block does not enforce it.

module key_auto_repeat
    import kar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_W-1:0]    tick_time,
    input  logic [MASK_W-1:0]    raw_keys,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [MASK_W-1:0]    fire_keys,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int PROD_W = CFG_W + DIV3_MULT_W;
    localparam logic [KEY_IDX_W-1:0] LAST_IDX = KEY_IDX_W'(ACTIVE_KEYS - 1);

    logic [CFG_W-1:0]     period_reg;
    logic [CFG_W-1:0]     hold_reg;
    logic [CFG_W-1:0]     fast_reg;
    logic [CFG_W-1:0]     fast_next;
    logic [PROD_W-1:0]    fast_prod;
    repeat_cfg_t          cfg;

    logic                 a_valid_reg;
    logic [TIME_W-1:0]    a_time_reg;
    logic [MASK_W-1:0]    a_keys_reg;
    logic [KEY_IDX_W-1:0] a_idx_reg;
    logic                 a_last;

    logic                 b_valid_reg;
    logic [TIME_W-1:0]    b_time_reg;
    logic [KEY_IDX_W-1:0] b_idx_reg;
    logic                 b_level_reg;
    logic                 b_last_reg;

    logic [MASK_W-1:0]    acc_reg;
    logic                 out_valid_reg;
    logic [MASK_W-1:0]    out_data_reg;

    logic                 hold;
    logic                 issue;
    logic                 accept;
    logic                 retire;
    key_state_t           cur_state;
    key_state_t           nxt_state;
    logic                 fired;
    logic [MASK_W-1:0]    fire_bit;

    always_comb
    begin
        fast_prod = PROD_W'(period_reg) * PROD_W'(DIV3_MULT);
        fast_next = fast_prod[DIV3_SHIFT +: CFG_W];
        cfg.period      = period_reg;
        cfg.fast_period = fast_reg;
        cfg.hold        = hold_reg;
    end

    assign a_last   = (a_idx_reg == LAST_IDX);
    assign hold     = b_valid_reg && b_last_reg && out_valid_reg && out_stall;
    assign issue    = a_valid_reg && !hold;
    assign in_stall = a_valid_reg && !(a_last && !hold);
    assign accept   = in_valid && !in_stall;
    assign retire   = b_valid_reg && !hold;
    assign fire_bit = MASK_W'(fired) << b_idx_reg;

    kar_state_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (issue),
        .rd_addr (a_idx_reg),
        .rd_data (cur_state),
        .wr_en   (retire),
        .wr_addr (b_idx_reg),
        .wr_data (nxt_state)
    );

    kar_key_unit u_key (
        .cfg   (cfg),
        .now   (b_time_reg),
        .level (b_level_reg),
        .cur   (cur_state),
        .nxt   (nxt_state),
        .fired (fired)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_time_reg <= tick_time;
            a_keys_reg <= raw_keys;
        end
        if (!hold)
        begin
            b_time_reg  <= a_time_reg;
            b_idx_reg   <= a_idx_reg;
            b_level_reg <= a_keys_reg[a_idx_reg];
        end
        if (retire && b_last_reg)
        begin
            out_data_reg <= acc_reg | fire_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= DEFAULT_PERIOD;
            hold_reg      <= DEFAULT_HOLD;
            fast_reg      <= DEFAULT_FAST;
            a_valid_reg   <= 1'b0;
            a_idx_reg     <= '0;
            b_valid_reg   <= 1'b0;
            b_last_reg    <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_REPEAT_PERIOD))
            begin
                period_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_HOLD_THRESHOLD))
            begin
                hold_reg <= cfg_data;
            end
            fast_reg <= fast_next;

            if (accept)
            begin
                a_valid_reg <= 1'b1;
                a_idx_reg   <= '0;
            end
            else if (issue)
            begin
                if (a_last)
                begin
                    a_valid_reg <= 1'b0;
                end
                else
                begin
                    a_idx_reg <= a_idx_reg + KEY_IDX_W'(1);
                end
            end

            if (!hold)
            begin
                b_valid_reg <= issue;
                b_last_reg  <= a_last;
            end

            if (retire)
            begin
                if (b_last_reg)
                begin
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_reg | fire_bit;
                end
            end

            if (retire && b_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign fire_keys = out_data_reg;

endmodule

### test/kar_fire_checker.sv
// kar_fire_checker: watches the tick, result and register ports of key_auto_repeat,
// predicts each fire mask from its own key state and compares; depends on kar_pkg
`timescale 1ns / 1ps

module kar_fire_checker
    import kar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [TIME_W-1:0]    tick_time,
    input  logic [MASK_W-1:0]    raw_keys,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [MASK_W-1:0]    fire_keys,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 run_done,
    output int                   fail_count
);

    logic [CFG_W-1:0]  period_r;
    logic [CFG_W-1:0]  hold_r;
    logic              key_held  [ACTIVE_KEYS];
    logic [TIME_W-1:0] press_at  [ACTIVE_KEYS];
    logic [TIME_W-1:0] last_fire [ACTIVE_KEYS];
    logic [MASK_W-1:0] fire_expect_q [$];
    logic [MASK_W-1:0] want;
    logic              drained;

    function automatic logic [MASK_W-1:0] next_fire_mask(input logic [TIME_W-1:0] now,
                                                         input logic [MASK_W-1:0] levels);
        logic [MASK_W-1:0] fired;
        logic [TIME_W-1:0] held_for;
        logic [TIME_W-1:0] since_fire;
        logic [CFG_W-1:0]  rate;
        int                k;
        fired = '0;
        for (k = 0; k < ACTIVE_KEYS; k++)
        begin
            if (levels[k] && !key_held[k])
            begin
                key_held[k]  = 1'b1;
                press_at[k]  = now;
                last_fire[k] = now;
                fired[k]     = 1'b1;
            end
            else
            begin
                if (!levels[k] && key_held[k])
                begin
                    key_held[k]  = 1'b0;
                    press_at[k]  = '0;
                    last_fire[k] = '0;
                end
                if (period_r != '0 && key_held[k])
                begin
                    rate     = period_r;
                    held_for = now - press_at[k];
                    if (hold_r != '0 && held_for > TIME_W'(hold_r))
                        rate = period_r / CFG_W'(SPEEDUP_DIV);
                    since_fire = now - last_fire[k];
                    if (since_fire > TIME_W'(rate))
                    begin
                        last_fire[k] = now;
                        fired[k]     = 1'b1;
                    end
                end
            end
        end
        return fired;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_r   = DEFAULT_PERIOD;
            hold_r     = DEFAULT_HOLD;
            fail_count = 0;
            drained    = 1'b0;
            fire_expect_q.delete();
            for (int k = 0; k < ACTIVE_KEYS; k++)
            begin
                key_held[k]  = 1'b0;
                press_at[k]  = '0;
                last_fire[k] = '0;
            end
        end
        else
        begin
            // result side first, so a word never matches an expectation made this edge
            if (out_valid && !out_stall)
            begin
                if (fire_expect_q.size() == 0)
                begin
                    $display("%0t: fire_keys word with nothing expected, expected none actual %h",
                             $time, fire_keys);
                    fail_count++;
                end
                else
                begin
                    want = fire_expect_q.pop_front();
                    if (fire_keys !== want)
                    begin
                        $display("%0t: fire_keys mismatch, expected %h actual %h",
                                 $time, want, fire_keys);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_REPEAT_PERIOD)
                    period_r = cfg_data;
                else if (cfg_index == REG_HOLD_THRESHOLD)
                    hold_r = cfg_data;
            end
            if (in_valid && !in_stall)
                fire_expect_q.push_back(next_fire_mask(tick_time, raw_keys));
            if (run_done && !drained)
            begin
                drained = 1'b1;
                if (fire_expect_q.size() != 0)
                begin
                    $display("%0t: fire_keys words missing, expected %0d more actual 0",
                             $time, fire_expect_q.size());
                    fail_count += fire_expect_q.size();
                end
            end
        end
    end

endmodule

### test/tb_top.sv
// tb_top: stimulus and verdict for key_auto_repeat; directed ticks, then random key sequences
// under several register settings; depends on kar_pkg, key_auto_repeat, kar_fire_checker
`timescale 1ns / 1ps

module tb_top;
    import kar_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);
    localparam int NUM_PHASES      = 11;
    localparam int TICKS_PER_PHASE = 100;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [TIME_W-1:0]    tick_time = '0;
    logic [MASK_W-1:0]    raw_keys  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [MASK_W-1:0]    fire_keys;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 run_done  = 1'b0;
    int                   fail_count;

    int sent_count = 0;
    int got_count  = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int span_left  = 0;

    key_auto_repeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .tick_time (tick_time),
        .raw_keys  (raw_keys),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .fire_keys (fire_keys),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kar_fire_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .tick_time  (tick_time),
        .raw_keys   (raw_keys),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .fire_keys  (fire_keys),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .run_done   (run_done),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            got_count <= got_count + 1;
    end

    // receiver: free stretches, light random stalls, heavy stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            span_left  <= 0;
        end
        else
        begin
            if (span_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                span_left  <= $urandom_range(20, 200);
            end
            else
                span_left <= span_left - 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic push_tick(input logic [TIME_W-1:0] t, input logic [MASK_W-1:0] k);
        in_valid  <= 1'b1;
        tick_time <= t;
        raw_keys  <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 40))
                    @(posedge clk);
            end
        end
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (got_count != sent_count)
            @(posedge clk);
        repeat (2 * ACTIVE_KEYS)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [CFG_W-1:0] per, input logic [CFG_W-1:0] hld);
        write_reg(REG_REPEAT_PERIOD, per);
        write_reg(REG_HOLD_THRESHOLD, hld);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [TIME_W-1:0] now_t;
        logic [MASK_W-1:0] keys_now;
        logic [CFG_W-1:0]  per;
        logic [CFG_W-1:0]  hld;
        int                step_max;
        int                ph;
        int                n;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: edges, first repeat, speed-up, release, wrap
        push_tick(32'd0, 16'h0000);
        push_tick(32'd5, 16'hFFFF);
        push_tick(32'd100, 16'hFFFF);
        push_tick(32'd206, 16'hFFFF);
        push_tick(32'd1006, 16'hFFFF);
        push_tick(32'd1073, 16'hFFFF);
        push_tick(32'd1080, 16'h0000);
        push_tick(32'd1081, 16'h5555);
        push_tick(32'd1082, 16'hAAAA);
        push_tick(32'hFFFF_FFF0, 16'h0001);
        push_tick(32'h0000_00C0, 16'h0001);
        push_tick(32'hFFFF_FFFF, 16'h8001);
        settle_idle();

        // writes to unused indexes must change nothing
        write_reg(REG_UNUSED_2, 16'hFFFF);
        write_reg(REG_UNUSED_3, 16'h0000);
        cfg_we <= 1'b0;
        @(posedge clk);
        push_tick(32'h0000_0300, 16'h8001);
        settle_idle();

        // repeat disabled
        set_registers(16'd0, 16'd1000);
        push_tick(32'h0000_0320, 16'h0003);
        push_tick(32'h7FFF_FFFF, 16'h0003);
        push_tick(32'h8000_0000, 16'h0000);
        settle_idle();

        // tiny period: rate drops to zero after speed-up
        set_registers(16'd2, 16'd1);
        push_tick(32'd100, 16'h00FF);
        push_tick(32'd101, 16'h00FF);
        push_tick(32'd103, 16'h00FF);
        push_tick(32'd103, 16'h00FF);
        push_tick(32'd104, 16'h00FF);
        settle_idle();

        // widest registers
        set_registers(16'hFFFF, 16'hFFFF);
        push_tick(32'd0, 16'hFFFF);
        push_tick(32'd65535, 16'hFFFF);
        push_tick(32'd65536, 16'hFFFF);
        push_tick(32'd87382, 16'hFFFF);

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle_idle();
            case (ph)
                0:       begin per = 16'd0;     hld = 16'd1000;  end
                1:       begin per = 16'hFFFF;  hld = 16'hFFFF;  end
                2:       begin per = 16'd1;     hld = 16'd1;     end
                3:       begin per = 16'd2;     hld = 16'd0;     end
                4:       begin per = 16'd3;     hld = 16'd5;     end
                5:       begin per = 16'd20;    hld = 16'd60;    end
                6:       begin per = DEFAULT_PERIOD; hld = DEFAULT_HOLD; end
                7:       begin per = 16'd7;     hld = 16'd0;     end
                8:
                begin
                    per = CFG_W'($urandom_range(1, 40));
                    hld = CFG_W'($urandom_range(0, 100));
                end
                9:
                begin
                    per = CFG_W'($urandom);
                    hld = CFG_W'($urandom);
                end
                default:
                begin
                    per = CFG_W'($urandom_range(0, 12));
                    hld = CFG_W'($urandom_range(0, 30));
                end
            endcase
            set_registers(per, hld);

            if (per == '0)
                step_max = 8;
            else if (per > 16'd64)
                step_max = per / 8 + 1;
            else
                step_max = per / 2 + 2;

            if ($urandom_range(0, 2) == 0)
                now_t = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            else
                now_t = $urandom;
            keys_now = MASK_W'($urandom);

            for (n = 0; n < TICKS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    now_t = $urandom;
                else
                    now_t = now_t + $urandom_range(0, step_max);
                if ($urandom_range(0, 19) == 0)
                    keys_now = MASK_W'($urandom);
                else
                    keys_now = keys_now ^ MASK_W'($urandom & $urandom & $urandom);
                push_tick(now_t, keys_now);
            end
        end

        settle_idle();
        run_done <= 1'b1;
        repeat (2)
            @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### key_auto_repeat.f
hdl/kar_pkg.sv
hdl/kar_state_mem.sv
hdl/kar_key_unit.sv
hdl/key_auto_repeat.sv
test/kar_fire_checker.sv
test/tb_top.sv
